FILE: rtl/core/b32d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32d_pkg: shared types and constants for the base32 stream decoder
// Character codes, status codes and the symbol-to-digit lookup.
// ----------------------------------------------------------------------------
package b32d_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  // Characters that are skipped
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChDash  = 8'h2D;

  // Look-alike digits and their letters
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChUpO   = 8'h4F;
  localparam logic [7:0] ChUpL   = 8'h4C;
  localparam logic [7:0] ChUpB   = 8'h42;

  // Alphabet bounds
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] DigitOffset = 8'd24;  // '2' maps to 26

  localparam logic [16:0] CharCountMax = 17'h1FFFF;

  // Returns {invalid, value[4:0]}; invalid set for codes outside the alphabet
  function automatic logic [5:0] digit_value(input logic [7:0] ch);
    logic [7:0] c;
    logic [7:0] d;
    c = ch;
    if (ch == ChZero) begin
      c = ChUpO;
    end else if (ch == ChOne) begin
      c = ChUpL;
    end else if (ch == ChEight) begin
      c = ChUpB;
    end
    d = c - DigitOffset;
    if ((c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ)) begin
      digit_value = {1'b0, c[4:0] - 5'd1};
    end else if (c >= ChTwo && c <= ChSeven) begin
      digit_value = {1'b0, d[4:0]};
    end else begin
      digit_value = 6'b100000;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/base32_stream_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base32_stream_decoder_core: streaming base32 text decoder
// One character per transfer in, one result per character out; bytes are
// assembled five bits at a time with a byte limit and sticky error status.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------------
//  input     | in        | in_valid_i/in_ready_o  | in_char_i, last_char_i
//  result    | out       | out_valid_o/out_ready_i| data_byte_o, byte_valid_o,
//            |           |                        | string_done_o, status_o,
//            |           |                        | bytes_out_o
//  config    | in        | cfg_we_i               | cfg_max_bytes_i
//
//  One character per cycle sustained while results are accepted; the input
//  register captures the character at the transfer and the result register
//  takes it from there. Decode, counter and limit compare sit in one stage
//  between the two. Reset clears the string state and sets the byte limit
//  to 64. A stalled result holds the pipe; the input register still takes
//  one character while the result waits.
// ----------------------------------------------------------------------------
module base32_stream_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_max_bytes_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        last_char_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       data_byte_o,
  output logic             byte_valid_o,
  output logic             string_done_o,
  output logic [1:0]       status_o,
  output logic [15:0]      bytes_out_o
);
  import b32d_pkg::*;

  // configuration register
  logic [15:0] max_bytes_q;

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_char_q;
  logic        s1_last_q;

  // string state
  logic [11:0] acc_q, acc_d;
  logic [3:0]  held_q, held_d;
  logic [15:0] byte_total_q, byte_total_d;
  logic [16:0] char_total_q, char_total_d;
  logic        bad_q, bad_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  data_q, data_d;
  logic        bvalid_q, bvalid_d;
  logic        done_q;
  status_e     status_q, status_d;
  logic [15:0] bytes_q;

  logic        in_xfer, advance, step;
  logic        skip, take;
  logic [5:0]  dv;
  logic [11:0] acc_sh, acc_out;
  logic [3:0]  held_sum;
  logic [2:0]  sh;
  logic [19:0] chars_x5, limit_x7;

  // handshake
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign step       = s1_valid_q && advance;

  always_comb begin
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  // character decode
  assign skip = (s1_char_q == ChSpace) || (s1_char_q == ChTab) || (s1_char_q == ChCr) ||
                (s1_char_q == ChLf) || (s1_char_q == ChDash);
  assign dv   = digit_value(s1_char_q);
  assign take = !skip && !bad_q && (byte_total_q < max_bytes_q);

  assign acc_sh   = {acc_q[6:0], dv[4:0]};
  assign held_sum = held_q + 4'd5;
  assign sh       = 3'(held_sum - 4'd8);
  assign acc_out  = acc_sh >> sh;

  // length check: 5 * chars against 7 * limit
  assign chars_x5 = 20'({char_total_d, 2'b00}) + 20'(char_total_d);
  assign limit_x7 = 20'({max_bytes_q, 3'b000}) - 20'(max_bytes_q);

  // next string state and result
  always_comb begin
    acc_d        = acc_q;
    held_d       = held_q;
    byte_total_d = byte_total_q;
    bad_d        = bad_q;
    data_d       = 8'd0;
    bvalid_d     = 1'b0;
    char_total_d = (char_total_q != CharCountMax) ? char_total_q + 17'd1 : char_total_q;

    if (take) begin
      if (dv[5]) begin
        bad_d = 1'b1;
      end else if (held_sum >= 4'd8) begin
        data_d       = acc_out[7:0];
        bvalid_d     = 1'b1;
        held_d       = {1'b0, sh};
        acc_d        = acc_sh & 12'((12'd1 << sh) - 12'd1);
        byte_total_d = byte_total_q + 16'd1;
      end else begin
        acc_d  = acc_sh;
        held_d = held_sum;
      end
    end

    if (s1_last_q && (chars_x5 > limit_x7)) begin
      status_d = STATUS_TOO_LONG;
    end else if (bad_d) begin
      status_d = STATUS_BAD_CHAR;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q  <= 16'd64;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      acc_q        <= '0;
      held_q       <= '0;
      byte_total_q <= '0;
      char_total_q <= '0;
      bad_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_max_bytes_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        if (s1_last_q) begin
          acc_q        <= '0;
          held_q       <= '0;
          byte_total_q <= '0;
          char_total_q <= '0;
          bad_q        <= 1'b0;
        end else begin
          acc_q        <= acc_d;
          held_q       <= held_d;
          byte_total_q <= byte_total_d;
          char_total_q <= char_total_d;
          bad_q        <= bad_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_char_q <= in_char_i;
      s1_last_q <= last_char_i;
    end
    if (step) begin
      data_q   <= data_d;
      bvalid_q <= bvalid_d;
      done_q   <= s1_last_q;
      status_q <= status_d;
      bytes_q  <= byte_total_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = data_q;
  assign byte_valid_o  = bvalid_q;
  assign string_done_o = done_q;
  assign status_o      = status_q;
  assign bytes_out_o   = bytes_q;

  // checks
  a_held_below_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q < 4'd8)
    else $error("bit count reached a full byte without emitting");

  a_byte_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |-> (bytes_out_o != 16'd0))
    else $error("byte emitted with zero byte count");

  a_too_long_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_TOO_LONG) |-> string_done_o)
    else $error("length status on a non-final character");

  a_limit_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |-> (bytes_out_o <= max_bytes_q))
    else $error("byte emitted past the limit");

endmodule
`default_nettype wire
